// File: rtl/core/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types, register indices and fixed-point helpers of the stencil unit.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int unsigned InTdataW  = 288;
  localparam int unsigned OutTdataW = 64;
  localparam int unsigned CfgW      = 31;

  typedef enum logic [2:0] {
    REG_BETA       = 3'd0,
    REG_POROSITY   = 3'd1,
    REG_DT_DENSITY = 3'd2,
    REG_INV_DY     = 3'd3,
    REG_INV_DZ     = 3'd4,
    REG_ROW_LENGTH = 3'd5,
    REG_ROW_COUNT  = 3'd6,
    REG_SPARE      = 3'd7
  } reg_idx_e;

  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;

  // Request to and response from the divider.
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  // Saturates a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'(QMax)) begin
      r = QMax;
    end else if (x < 64'(QMin)) begin
      r = QMin;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Rounds an exact Q34.32 product to Q16.16: add one half, floor, saturate.
  function automatic logic signed [31:0] qround(input logic signed [65:0] prod);
    logic signed [66:0] t;
    logic signed [66:0] s;
    t = 67'(prod) + 67'sd32768;
    s = t >>> 16;
    return sat32(s[63:0]);
  endfunction

endpackage

// File: rtl/core/pvs_ram.sv
// ----------------------------------------------------------------------------
// pvs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pvs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/pvs_qdiv.sv
// ----------------------------------------------------------------------------
// pvs_qdiv
// Q16.16 divider, restoring, one quotient bit per cycle, rounds to nearest.
// ----------------------------------------------------------------------------
module pvs_qdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvs_pkg::div_req_t  req_i,
  output pvs_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned DvdW = 49;

  logic            busy_q;
  logic [5:0]      cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [31:0]     rem_q;
  logic [31:0]     dabs_q;
  logic            neg_q;
  logic            done_q;
  logic [31:0]     quot_q;

  logic [32:0]     num_abs;
  logic [32:0]     den_abs;
  logic [32:0]     trial;
  logic            ge;
  logic [31:0]     qclamp;
  logic [31:0]     qfinal;

  always_comb begin
    num_abs = req_i.num[31] ? 33'd0 - 33'(req_i.num) : 33'(req_i.num);
    den_abs = req_i.den[31] ? 33'd0 - 33'(req_i.den) : 33'(req_i.den);
    trial   = {rem_q, dvd_q[DvdW-1]};
    ge      = trial >= {1'b0, dabs_q};
    qclamp  = (dvd_q > DvdW'(33'h0_8000_0000)) ? 32'h8000_0000 : dvd_q[31:0];
    if (neg_q) begin
      qfinal = 32'd0 - qclamp;
    end else if (qclamp[31]) begin
      qfinal = pvs_pkg::QMax;
    end else begin
      qfinal = qclamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (req_i.start) begin
        if (req_i.den == '0) begin
          done_q <= 1'b1;
          if (req_i.num == '0) begin
            quot_q <= '0;
          end else begin
            quot_q <= req_i.num[31] ? pvs_pkg::QMin : pvs_pkg::QMax;
          end
        end else begin
          done_q <= 1'b0;
          busy_q <= 1'b1;
          cnt_q  <= 6'(DvdW);
          rem_q  <= '0;
          dabs_q <= den_abs[31:0];
          neg_q  <= req_i.num[31] ^ req_i.den[31];
          dvd_q  <= DvdW'({num_abs[31:0], 16'h0000}) + DvdW'(den_abs[32:1]);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quot_q <= qfinal;
        end else begin
          done_q <= 1'b0;
          rem_q <= ge ? 32'(trial - {1'b0, dabs_q}) : trial[31:0];
          dvd_q <= {dvd_q[DvdW-2:0], ge};
          cnt_q <= cnt_q - 6'd1;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: rtl/core/porous_velocity_stencil_unit.sv
// ----------------------------------------------------------------------------
// porous_velocity_stencil_unit
// Damped porous-media velocity update on a 2-D grid, one point per transfer.
// ----------------------------------------------------------------------------
// Sequence: a border point only writes the line store and yields no result;
//   an interior point runs four divisions on the shared bit-serial divider
//   plus 13 multiplies before its result. One point is in flight; the next is
//   taken once a border point has written the line store, or once the result
//   sits in the output register, even while that result still waits.
// Reset: asynchronous, active low; clears control state and counters and sets
//   the configuration registers to defaults. The line store itself is not cleared.
// ----------------------------------------------------------------------------
module porous_velocity_stencil_unit #(
  parameter int unsigned MAX_ROW = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Fields from bit 0 up: velocity_y, velocity_z, pressure, jacobian (31 bit),
  // zz_metric, zy_metric, yy_metric, yz_metric, area_factor, one zero bit.
  input  logic [pvs_pkg::InTdataW-1:0]     s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: velocity_y_increment, velocity_z_increment.
  output logic [pvs_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [pvs_pkg::CfgW-1:0]         cfg_data_i
);

  localparam int unsigned ColW = $clog2(MAX_ROW);
  localparam int unsigned LenW = $clog2(MAX_ROW + 1);

  typedef enum logic [2:0] {S_IDLE, S_LINE, S_MUL, S_DIV, S_OUT} state_e;

  // Multiply program: each step is one rounded Q16.16 product.
  typedef enum logic [3:0] {
    M_GY, M_T1, M_GZ, M_SY, M_HZ, M_T3, M_HY, M_SZ,
    M_PA, M_DEN, M_X, M_CY, M_CZ, M_NONE0, M_NONE1, M_NONE2
  } mul_op_e;

  typedef enum logic [1:0] {D_C1, D_C, D_RY, D_RZ} div_op_e;

  // Configuration registers.
  logic [30:0] beta_q, dto_q, inv_dy_q, inv_dz_q;
  logic [16:0] porosity_q;
  logic [12:0] row_length_q, row_count_q;

  // Control state.
  state_e      state_q;
  mul_op_e     mul_op_q;
  div_op_e     div_op_q;
  logic        mul_wb_q;
  logic        div_wait_q;
  logic [ColW-1:0] col_q, col_lat_q;
  logic [11:0] row_q;
  logic        inner_q;
  logic signed [31:0] prior_q;
  logic        out_valid_q;
  logic [pvs_pkg::OutTdataW-1:0] out_data_q;

  // Latched item and working values.
  logic signed [31:0] vy_q, vz_q, p_q, zz_q, zy_q, yy_q, yz_q, area_q;
  logic [30:0]        jac_q;
  logic signed [31:0] dpy_q, dpz_q, g_q, t1_q, sy_q, t3_q, sz_q;
  logic signed [31:0] pa_q, den_q, x_q, c1_q, c_q, cy_q, cz_q, dy_q, dz_q;
  logic signed [65:0] prod_q;

  logic               accept;
  logic [LenW-1:0]    len_eff;
  logic [12:0]        rows_eff;
  logic               inner_now;
  logic               row_end;
  logic signed [31:0] in_p;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] mul_r;
  logic [31:0]        line_rdata;
  logic signed [31:0] ry, rz;
  logic               out_free;
  pvs_pkg::div_req_t  div_req;
  pvs_pkg::div_rsp_t  div_rsp;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_p          = s_axis_tdata[95:64];
  assign out_free      = !out_valid_q || m_axis_tready;

  // Geometry is clamped to the supported range before use.
  always_comb begin
    if (32'(row_length_q) < 32'd3) begin
      len_eff = LenW'(3);
    end else if (32'(row_length_q) > 32'(MAX_ROW)) begin
      len_eff = LenW'(MAX_ROW);
    end else begin
      len_eff = LenW'(row_length_q);
    end
    if (row_count_q < 13'd3) begin
      rows_eff = 13'd3;
    end else if (row_count_q > 13'd4096) begin
      rows_eff = 13'd4096;
    end else begin
      rows_eff = row_count_q;
    end
    row_end   = (32'(col_q) + 32'd1) >= 32'(len_eff);
    inner_now = (col_q != '0) && !row_end && (row_q != '0) &&
                ((13'(row_q) + 13'd1) < rows_eff);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (mul_op_q)
      M_GY:    begin mul_a = 33'(zz_q); mul_b = 33'($signed({1'b0, inv_dy_q})); end
      M_T1:    begin mul_a = 33'(g_q);  mul_b = 33'(dpy_q); end
      M_GZ:    begin mul_a = 33'(zy_q); mul_b = 33'($signed({1'b0, inv_dz_q})); end
      M_SY:    begin mul_a = 33'(g_q);  mul_b = 33'(dpz_q); end
      M_HZ:    begin mul_a = 33'(yy_q); mul_b = 33'($signed({1'b0, inv_dz_q})); end
      M_T3:    begin mul_a = 33'(g_q);  mul_b = 33'(dpz_q); end
      M_HY:    begin mul_a = 33'(yz_q); mul_b = 33'($signed({1'b0, inv_dy_q})); end
      M_SZ:    begin mul_a = 33'(g_q);  mul_b = 33'(dpy_q); end
      M_PA:    begin
        mul_a = 33'($signed({1'b0, porosity_q}));
        mul_b = 33'(area_q);
      end
      M_DEN:   begin mul_a = 33'($signed({1'b0, beta_q})); mul_b = 33'(pa_q); end
      M_X:     begin mul_a = 33'($signed({1'b0, dto_q}));  mul_b = 33'(pa_q); end
      M_CY:    begin mul_a = 33'(c_q);  mul_b = 33'(sy_q); end
      M_CZ:    begin mul_a = 33'(c_q);  mul_b = 33'(sz_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_r = pvs_pkg::qround(prod_q);
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_req.start = (state_q == S_DIV) && !div_wait_q;
    unique case (div_op_q)
      D_C1:    begin div_req.num = x_q;  div_req.den = $signed({1'b0, jac_q}); end
      D_C:     begin div_req.num = c1_q; div_req.den = den_q; end
      D_RY:    begin div_req.num = vy_q; div_req.den = den_q; end
      D_RZ:    begin div_req.num = vz_q; div_req.den = den_q; end
      default: begin div_req.num = '0;   div_req.den = '0;    end
    endcase
  end

  // Final sums are formed exactly and saturated once.
  always_comb begin
    ry = pvs_pkg::sat32(64'sd0 - 64'(vy_q) - 64'(cy_q) + 64'(dy_q));
    rz = pvs_pkg::sat32(64'sd0 - 64'(vz_q) - 64'(cz_q) + 64'(dz_q));
  end

  // Line store of the previous row's pressures. It is read in the cycle of
  // the input transfer and written in the next cycle, so a point always sees
  // the value left by the row above.
  pvs_ram #(
    .Width (32),
    .Depth (MAX_ROW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (state_q == S_LINE),
    .waddr_i (col_lat_q),
    .wdata_i (p_q),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  pvs_qdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q       <= '0;
      porosity_q   <= 17'd65536;
      dto_q        <= '0;
      inv_dy_q     <= 31'd65536;
      inv_dz_q     <= 31'd65536;
      row_length_q <= 13'd4096;
      row_count_q  <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (pvs_pkg::reg_idx_e'(cfg_index_i))
        pvs_pkg::REG_BETA:       beta_q       <= cfg_data_i;
        pvs_pkg::REG_POROSITY:   porosity_q   <= cfg_data_i[16:0];
        pvs_pkg::REG_DT_DENSITY: dto_q        <= cfg_data_i;
        pvs_pkg::REG_INV_DY:     inv_dy_q     <= cfg_data_i;
        pvs_pkg::REG_INV_DZ:     inv_dz_q     <= cfg_data_i;
        pvs_pkg::REG_ROW_LENGTH: row_length_q <= cfg_data_i[12:0];
        pvs_pkg::REG_ROW_COUNT:  row_count_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Item latch and working values; these carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vy_q      <= s_axis_tdata[31:0];
      vz_q      <= s_axis_tdata[63:32];
      p_q       <= in_p;
      jac_q     <= s_axis_tdata[126:96];
      zz_q      <= s_axis_tdata[158:127];
      zy_q      <= s_axis_tdata[190:159];
      yy_q      <= s_axis_tdata[222:191];
      yz_q      <= s_axis_tdata[254:223];
      area_q    <= s_axis_tdata[286:255];
      col_lat_q <= col_q;
      dpy_q     <= pvs_pkg::sat32(64'(in_p) - 64'(prior_q));
    end
    if (state_q == S_LINE) begin
      dpz_q <= pvs_pkg::sat32(64'(p_q) - 64'($signed(line_rdata)));
    end
    if (state_q == S_MUL && !mul_wb_q) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == S_MUL && mul_wb_q) begin
      unique case (mul_op_q)
        M_GY, M_GZ, M_HZ, M_HY: g_q <= mul_r;
        M_T1:  t1_q  <= mul_r;
        M_SY:  sy_q  <= pvs_pkg::sat32(64'(t1_q) - 64'(mul_r));
        M_T3:  t3_q  <= mul_r;
        M_SZ:  sz_q  <= pvs_pkg::sat32(64'(t3_q) - 64'(mul_r));
        M_PA:  pa_q  <= mul_r;
        M_DEN: den_q <= pvs_pkg::sat32(64'(pvs_pkg::QOne) + 64'(mul_r));
        M_X:   x_q   <= mul_r;
        M_CY:  cy_q  <= mul_r;
        M_CZ:  cz_q  <= mul_r;
        default: ;
      endcase
    end
    if (state_q == S_DIV && div_wait_q && div_rsp.done) begin
      unique case (div_op_q)
        D_C1:    c1_q <= div_rsp.quot;
        D_C:     c_q  <= div_rsp.quot;
        D_RY:    dy_q <= div_rsp.quot;
        D_RZ:    dz_q <= div_rsp.quot;
        default: ;
      endcase
    end
  end

  // Sequencer: counters, step control and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_op_q    <= M_GY;
      div_op_q    <= D_C1;
      mul_wb_q    <= 1'b0;
      div_wait_q  <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      inner_q     <= 1'b0;
      prior_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // A result taken while a new one is loaded is replaced in S_OUT below.
      if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            inner_q <= inner_now;
            prior_q <= in_p;
            state_q <= S_LINE;
            if (row_end) begin
              col_q <= '0;
              row_q <= ((13'(row_q) + 13'd1) >= rows_eff) ? 12'd0 : row_q + 12'd1;
            end else begin
              col_q <= col_q + ColW'(1);
            end
          end
        end
        S_LINE: begin
          mul_op_q <= M_GY;
          mul_wb_q <= 1'b0;
          state_q  <= inner_q ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          mul_wb_q <= !mul_wb_q;
          if (mul_wb_q) begin
            if (mul_op_q == M_X) begin
              div_op_q <= D_C1;
              state_q  <= S_DIV;
            end else if (mul_op_q == M_CZ) begin
              div_op_q <= D_RY;
              state_q  <= S_DIV;
            end else begin
              mul_op_q <= mul_op_e'(mul_op_q + 4'd1);
            end
          end
        end
        S_DIV: begin
          if (!div_wait_q) begin
            div_wait_q <= 1'b1;
          end else if (div_rsp.done) begin
            div_wait_q <= 1'b0;
            unique case (div_op_q)
              D_C1: div_op_q <= D_C;
              D_C: begin
                mul_op_q <= M_CY;
                mul_wb_q <= 1'b0;
                state_q  <= S_MUL;
              end
              D_RY: div_op_q <= D_RZ;
              D_RZ: state_q  <= S_OUT;
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {rz, ry};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/core/pvs_checker.sv
// ----------------------------------------------------------------------------
// pvs_checker
// Port-level checks of the stencil unit, bound to the top level.
// ----------------------------------------------------------------------------
module pvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One point at a time: the unit is busy right after taking a point.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second point taken while busy");

  // A new result never appears in the cycle right after a point arrives.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind porous_velocity_stencil_unit pvs_checker u_pvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
